/* rtl/core/io_bank_switch_and_ram_file_macros.svh */
// ----------------------------------------------------------------------------
// I/O bank switch and RAM file: assertion macros
// Shared property shapes for the checkers of this block.
// ----------------------------------------------------------------------------
`ifndef IO_BANK_SWITCH_AND_RAM_FILE_MACROS_SVH
`define IO_BANK_SWITCH_AND_RAM_FILE_MACROS_SVH

// Same-cycle implication, masked while reset is held
`define IBSRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ibsrf assertion failed");

// Next-cycle implication, masked while reset is held
`define IBSRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ibsrf assertion failed");

`endif

/* rtl/core/ibsrf_pkg.sv */
// ----------------------------------------------------------------------------
// ibsrf_pkg
// Types, port codes and the memory map decode of the bank switch block.
// ----------------------------------------------------------------------------
`default_nettype none

package ibsrf_pkg;

  // RAM file geometry
  localparam int FILE_ADDR_BITS = 16;
  localparam int STORE_DEPTH    = 1 << FILE_ADDR_BITS;
  localparam int PTR_W          = 16;
  localparam int PORT_W         = 16;
  localparam int DATA_W         = 8;
  localparam int MAP_W          = 3;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Port codes, low address byte
  localparam logic [7:0] PORT_LO_SET  = 8'hE0;
  localparam logic [7:0] PORT_HI_SET  = 8'hE1;
  localparam logic [7:0] PORT_LO_CLR  = 8'hE2;
  localparam logic [7:0] PORT_HI_CLR  = 8'hE3;
  localparam logic [7:0] PORT_ALL_CLR = 8'hE4;
  localparam logic [7:0] PORT_INH_SET = 8'hE5;
  localparam logic [7:0] PORT_INH_CLR = 8'hE6;
  localparam logic [7:0] PORT_DATA    = 8'hEA;
  localparam logic [7:0] PORT_PTR     = 8'hEB;

  // Byte returned by reads of every port but the data port
  localparam logic [DATA_W-1:0] FLOAT_BYTE = 8'hFF;

  // Memory map numbers
  localparam logic [MAP_W-1:0] MAP_ALL_DRAM  = 3'd0;
  localparam logic [MAP_W-1:0] MAP_LO_DRAM   = 3'd1;
  localparam logic [MAP_W-1:0] MAP_INH_LO    = 3'd2;
  localparam logic [MAP_W-1:0] MAP_HI_DRAM   = 3'd3;
  localparam logic [MAP_W-1:0] MAP_ROM_MMIO  = 3'd4;
  localparam logic [MAP_W-1:0] MAP_INH_ROM   = 3'd5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the accepted access
    logic execute;   // decode, touch the store, step or load the pointer
    logic load;      // move the result into the output register
  } ibsrf_cmd_t;

  // Map number from the three bank flags
  function automatic logic [MAP_W-1:0] map_number(input logic lo_dram,
                                                  input logic hi_dram,
                                                  input logic inhibit);
    logic [MAP_W-1:0] m;
    if (inhibit) begin
      m = lo_dram ? MAP_INH_LO : MAP_INH_ROM;
    end else if (lo_dram) begin
      m = hi_dram ? MAP_ALL_DRAM : MAP_LO_DRAM;
    end else begin
      m = hi_dram ? MAP_HI_DRAM : MAP_ROM_MMIO;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ibsrf_if.sv */
// ----------------------------------------------------------------------------
// ibsrf channel interfaces
// Valid/ready channels for bus accesses in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

// Bus access channel
interface ibsrf_in_if import ibsrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [PORT_W-1:0] port_address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output opcode, output port_address,
                  output write_data, input ready);
  modport sink   (input valid, input opcode, input port_address,
                  input write_data, output ready);
endinterface

// Result channel
interface ibsrf_out_if import ibsrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [MAP_W-1:0]  memory_map;

  modport source (output valid, output read_data, output memory_map,
                  input ready);
  modport sink   (input valid, input read_data, input memory_map,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/ibsrf_ctrl.sv */
// ----------------------------------------------------------------------------
// ibsrf_ctrl
// Sequencer: capture one access, execute it, then hand the result word to
// the output register once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ibsrf_ctrl import ibsrf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output ibsrf_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output register can take a word this cycle
  assign out_free = !out_valid_r || out_ready;

  // Commands
  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.execute = (state_r == S_EXEC);
    cmd.load    = (state_r == S_LOAD) && out_free;
  end

  // Next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/ibsrf_dp.sv */
// ----------------------------------------------------------------------------
// ibsrf_dp
// Bank flags, file pointer, RAM file store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ibsrf_dp import ibsrf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ibsrf_cmd_t        cmd,
  input  wire logic              in_opcode,
  input  wire logic [PORT_W-1:0] in_port_address,
  input  wire logic [DATA_W-1:0] in_write_data,
  output logic [DATA_W-1:0]      out_read_data,
  output logic [MAP_W-1:0]       out_memory_map
);

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_FLOAT,
    RS_STORE
  } rsel_t;

  // Captured access
  logic              op_r;
  logic [PORT_W-1:0] port_r;
  logic [DATA_W-1:0] wdata_r;

  // Bank flags and pointer
  logic              lo_r, lo_nxt;
  logic              hi_r, hi_nxt;
  logic              inh_r, inh_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;

  // Store and its registered read port
  logic [DATA_W-1:0] store_mem [STORE_DEPTH];
  logic [DATA_W-1:0] rd_q_r;
  logic [FILE_ADDR_BITS-1:0] store_idx;
  logic              store_we;

  // Result path
  rsel_t             rsel_r, rsel_nxt;
  logic [DATA_W-1:0] rdata_r;
  logic [MAP_W-1:0]  map_r;

  logic [7:0]        port_lo;

  assign port_lo   = port_r[7:0];
  assign store_idx = ptr_r[FILE_ADDR_BITS-1:0];
  assign store_we  = cmd.execute && (op_r == OP_WRITE) && (port_lo == PORT_DATA);

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_opcode;
      port_r  <= in_port_address;
      wdata_r <= in_write_data;
    end
  end

  // Decode bank ports, step or load the pointer, pick the result source
  always_comb begin
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    inh_nxt  = inh_r;
    ptr_nxt  = ptr_r;
    rsel_nxt = rsel_r;
    case (port_lo)
      PORT_LO_SET:  lo_nxt = 1'b1;
      PORT_HI_SET:  hi_nxt = 1'b1;
      PORT_LO_CLR:  lo_nxt = 1'b0;
      PORT_HI_CLR:  hi_nxt = 1'b0;
      PORT_ALL_CLR: begin
        lo_nxt  = 1'b0;
        hi_nxt  = 1'b0;
        inh_nxt = 1'b0;
      end
      PORT_INH_SET: inh_nxt = 1'b1;
      PORT_INH_CLR: inh_nxt = 1'b0;
      default: ;
    endcase
    if (op_r == OP_WRITE) begin
      rsel_nxt = RS_ZERO;
      if (port_lo == PORT_DATA) begin
        ptr_nxt = ptr_r + PTR_W'(1);
      end else if (port_lo == PORT_PTR) begin
        ptr_nxt = {port_r[15:8], wdata_r};
      end
    end else begin
      if (port_lo == PORT_DATA) begin
        rsel_nxt = RS_STORE;
        ptr_nxt  = ptr_r + PTR_W'(1);
      end else begin
        rsel_nxt = RS_FLOAT;
      end
    end
  end

  // Hold flags and pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r  <= 1'b0;
      hi_r  <= 1'b0;
      inh_r <= 1'b0;
      ptr_r <= '0;
    end else if (cmd.execute) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      inh_r <= inh_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // Result source select
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsel_r <= rsel_nxt;
    end
  end

  // RAM file: write at the pointer on a data-port write, read at the pointer on every execute
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_idx] <= wdata_r;
    end
    if (cmd.execute) begin
      rd_q_r <= store_mem[store_idx];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (rsel_r)
        RS_STORE: rdata_r <= rd_q_r;
        RS_FLOAT: rdata_r <= FLOAT_BYTE;
        default:  rdata_r <= '0;
      endcase
      map_r <= map_number(lo_r, hi_r, inh_r);
    end
  end

  assign out_read_data  = rdata_r;
  assign out_memory_map = map_r;

endmodule

`default_nettype wire

/* rtl/core/io_bank_switch_and_ram_file.sv */
// ----------------------------------------------------------------------------
// io_bank_switch_and_ram_file
// Bank switch decoder with a pointer-addressed RAM file on an I/O bus.
// ----------------------------------------------------------------------------
// Each bus access word is first latched on acceptance, then the flag decode,
// pointer step or load and the RAM file access at the pointer run, and then the result
// byte (registered store byte, float byte or zero) moves into the output
// register once that register is free. A new access is taken as soon as the
// sequencer is back in idle, even while the previous result still waits on the output.
// The RAM file has no reset; reading an entry before it was written returns
// an arbitrary byte.
`default_nettype none

module io_bank_switch_and_ram_file import ibsrf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ibsrf_in_if.sink    in_ch,
  ibsrf_out_if.source out_ch
);

  ibsrf_cmd_t cmd;

  // Sequencer
  ibsrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Flags, pointer, store, output register
  ibsrf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_ch.opcode),
    .in_port_address (in_ch.port_address),
    .in_write_data   (in_ch.write_data),
    .out_read_data   (out_ch.read_data),
    .out_memory_map  (out_ch.memory_map)
  );

endmodule

`default_nettype wire

/* rtl/core/ibsrf_checker.sv */
// ----------------------------------------------------------------------------
// ibsrf_checker
// Port-level checks of the bank switch block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "io_bank_switch_and_ram_file_macros.svh"

module ibsrf_checker import ibsrf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_read_data,
  input wire logic [MAP_W-1:0]  out_memory_map
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // Stalled result holds its word
  `IBSRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_data) && $stable(out_memory_map))

  // Map number stays in the decoded range
  `IBSRF_ASSERT_NOW(a_map_range, clk, rst_n, out_valid, out_memory_map <= MAP_INH_ROM)

  // One access in flight: no new word right after an accept
  `IBSRF_ASSERT_NEXT(a_one_inflight, clk, rst_n, in_acc, !in_ready)

  // A fresh result traces back to an accepted access, through the execute and load states
  `IBSRF_ASSERT_NOW(a_result_origin, clk, rst_n, $rose(out_valid), $past(in_acc, 3))

endmodule

bind io_bank_switch_and_ram_file ibsrf_checker u_ibsrf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_data  (out_ch.read_data),
  .out_memory_map (out_ch.memory_map)
);

`default_nettype wire

/* tb/io_bank_switch_and_ram_file_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_bank_switch_and_ram_file_checker
// Watches the access and result channels, keeps its own bank flags, file
// pointer and RAM file, and compares every result word field by field.
// ----------------------------------------------------------------------------
module io_bank_switch_and_ram_file_checker import ibsrf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ibsrf_in_if       in_ch,
  ibsrf_out_if      out_ch,
  output int        fail_count,
  output int        replies_outstanding
);

  localparam int STORE_MASK = STORE_DEPTH - 1;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [MAP_W-1:0]  memory_map;
  } bus_reply_t;

  logic              lo_dram;
  logic              hi_dram;
  logic              inhibit;
  logic [PTR_W-1:0]  file_ptr;
  logic [DATA_W-1:0] ram_file [int];
  bus_reply_t        replies_due [$];
  int                mismatches = 0;
  int                backlog = 0;

  assign fail_count          = mismatches;
  assign replies_outstanding = backlog;

  // Apply one access word to the shadow state and queue the reply it owes
  task automatic decode_access(input logic op, input logic [PORT_W-1:0] addr,
                               input logic [DATA_W-1:0] wdata);
    bus_reply_t reply;
    int         slot;
    slot = int'(file_ptr) & STORE_MASK;

    // Bank flags react to reads and writes alike
    case (addr[7:0])
      PORT_LO_SET:  lo_dram = 1'b1;
      PORT_HI_SET:  hi_dram = 1'b1;
      PORT_LO_CLR:  lo_dram = 1'b0;
      PORT_HI_CLR:  hi_dram = 1'b0;
      PORT_ALL_CLR: begin
        lo_dram = 1'b0;
        hi_dram = 1'b0;
        inhibit = 1'b0;
      end
      PORT_INH_SET: inhibit = 1'b1;
      PORT_INH_CLR: inhibit = 1'b0;
      default: ;
    endcase

    // RAM file access and pointer step or load; writes return zero
    reply.read_data = '0;
    if (op == OP_WRITE) begin
      if (addr[7:0] == PORT_DATA) begin
        ram_file[slot] = wdata;
        file_ptr       = file_ptr + PTR_W'(1);
      end else if (addr[7:0] == PORT_PTR) begin
        file_ptr = {addr[15:8], wdata};
      end
    end else if (addr[7:0] == PORT_DATA) begin
      reply.read_data = ram_file.exists(slot) ? ram_file[slot] : '0;
      file_ptr        = file_ptr + PTR_W'(1);
    end else begin
      reply.read_data = FLOAT_BYTE;
    end

    // Map number from the flags after this access
    if (inhibit) begin
      reply.memory_map = lo_dram ? MAP_INH_LO : MAP_INH_ROM;
    end else if (lo_dram) begin
      reply.memory_map = hi_dram ? MAP_ALL_DRAM : MAP_LO_DRAM;
    end else begin
      reply.memory_map = hi_dram ? MAP_HI_DRAM : MAP_ROM_MMIO;
    end
    replies_due.push_back(reply);
  endtask

  // Compare result words first, then take in the access word of the same edge
  always @(posedge clk) begin : watch_channels
    bus_reply_t due;
    if (!rst_n) begin
      lo_dram  = 1'b0;
      hi_dram  = 1'b0;
      inhibit  = 1'b0;
      file_ptr = '0;
      replies_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          $error("result word with no access waiting: read_data %0h memory_map %0d",
                 out_ch.read_data, out_ch.memory_map);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          if (out_ch.read_data !== due.read_data) begin
            $error("read_data: expected %0h, actual %0h", due.read_data, out_ch.read_data);
            mismatches++;
          end
          if (out_ch.memory_map !== due.memory_map) begin
            $error("memory_map: expected %0d, actual %0d", due.memory_map,
                   out_ch.memory_map);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_access(in_ch.opcode, in_ch.port_address, in_ch.write_data);
      end
    end
    backlog = replies_due.size();
  end

endmodule

/* tb/io_bank_switch_and_ram_file_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_bank_switch_and_ram_file_test
// Drives bus access words into the bank switch block, first a directed pass
// over every bank port, the pointer load and the pointer wrap, then random
// accesses, half of them RAM file traffic near filled entries, with random stalls
// on both channels and one long result hold-off. A checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module io_bank_switch_and_ram_file_test;
  import ibsrf_pkg::*;

  localparam int RANDOM_ACCESSES = 1925;
  localparam int QUIET_TAIL      = 200;
  localparam int HOLD_OFF_AT     = 400;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int STORE_MASK      = STORE_DEPTH - 1;

  logic             clk;
  logic             rst_n;
  int               fail_count;
  int               replies_outstanding;
  bit               quiet_tail   = 1'b0;
  bit               hold_off_due = 1'b0;
  logic [PTR_W-1:0] gen_ptr      = '0;
  bit               filled [int];
  logic [PTR_W-1:0] filled_slots [$];

  ibsrf_in_if  in_ch ();
  ibsrf_out_if out_ch ();

  io_bank_switch_and_ram_file i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  io_bank_switch_and_ram_file_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ch               (in_ch),
    .out_ch              (out_ch),
    .fail_count          (fail_count),
    .replies_outstanding (replies_outstanding)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #3_000_000;
    $display("io_bank_switch_and_ram_file verification failed");
    $finish;
  end

  // Offer one access word, hold it until taken, and track the file pointer
  // so that no read lands on an entry never written
  task automatic issue_access(input logic op, input logic [PORT_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
    int slot;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.port_address <= addr;
    in_ch.write_data   <= data;
    do @(posedge clk); while (!in_ch.ready);

    slot = int'(gen_ptr) & STORE_MASK;
    if (addr[7:0] == PORT_DATA) begin
      if (op == OP_WRITE && !filled.exists(slot)) begin
        filled[slot] = 1'b1;
        filled_slots.push_back(gen_ptr);
      end
      gen_ptr = gen_ptr + PTR_W'(1);
    end else if (addr[7:0] == PORT_PTR && op == OP_WRITE) begin
      gen_ptr = {addr[15:8], data};
    end
  endtask

  // Result side: random stall bursts, one long hold-off, steady at the end
  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (quiet_tail) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin : drive_accesses
    logic             op;
    logic [PORT_W-1:0] addr;
    logic [PTR_W-1:0]  target;
    logic [DATA_W-1:0] data;
    int                pick;
    int                waited;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_READ;
    in_ch.port_address <= '0;
    in_ch.write_data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Map after reset, then every bank port, the set ports as read and as write
    issue_access(OP_READ,  16'h00FF, 8'h00);
    issue_access(OP_WRITE, {8'h00, PORT_LO_SET},  8'hFF);
    issue_access(OP_READ,  {8'h12, PORT_HI_SET},  8'h00);
    issue_access(OP_WRITE, {8'hFF, PORT_INH_SET}, 8'h5A);
    issue_access(OP_READ,  {8'h80, PORT_LO_CLR},  8'hFF);
    issue_access(OP_WRITE, {8'h01, PORT_INH_CLR}, 8'h00);
    issue_access(OP_READ,  {8'h7F, PORT_HI_CLR},  8'h00);
    issue_access(OP_READ,  {8'hA5, PORT_LO_SET},  8'h00);
    issue_access(OP_READ,  {8'h00, PORT_INH_SET}, 8'h00);
    issue_access(OP_WRITE, {8'hC3, PORT_HI_SET},  8'h00);
    issue_access(OP_WRITE, {8'h3C, PORT_ALL_CLR}, 8'hFF);

    // Fill across the pointer wrap, reload and read it back
    issue_access(OP_WRITE, {8'hFF, PORT_PTR},  8'hFE);
    issue_access(OP_WRITE, {8'h00, PORT_DATA}, 8'h00);
    issue_access(OP_WRITE, {8'hFF, PORT_DATA}, 8'hFF);
    issue_access(OP_WRITE, {8'h5A, PORT_DATA}, 8'hA5);
    issue_access(OP_WRITE, {8'hFF, PORT_PTR},  8'hFE);
    issue_access(OP_READ,  {8'hAA, PORT_DATA}, 8'hFF);
    issue_access(OP_READ,  {8'h55, PORT_DATA}, 8'h00);
    issue_access(OP_READ,  {8'hFF, PORT_DATA}, 8'h5A);

    // Pointer port read, ignored write, floating reads, reload to zero
    issue_access(OP_READ,  {8'hFF, PORT_PTR},  8'hFF);
    issue_access(OP_WRITE, 16'h1234, 8'hFF);
    issue_access(OP_READ,  16'hFFFF, 8'hFF);
    issue_access(OP_READ,  16'h0000, 8'h00);
    issue_access(OP_WRITE, {8'h00, PORT_PTR},  8'h00);
    issue_access(OP_READ,  {8'h00, PORT_DATA}, 8'h00);

    // Random accesses, half of them picked as RAM file traffic around filled entries
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if (i == HOLD_OFF_AT) hold_off_due = 1'b1;
      if (i == RANDOM_ACCESSES - QUIET_TAIL) quiet_tail = 1'b1;
      op   = 1'($urandom_range(0, 1));
      addr = PORT_W'($urandom_range(0, 16'hFFFF));
      data = DATA_W'($urandom_range(0, 8'hFF));
      pick = int'($urandom_range(0, 99));
      if (pick < 35) begin
        addr[7:0] = PORT_DATA;
      end else if (pick < 50) begin
        // Reposition, mostly onto an entry that already holds data
        addr[7:0] = PORT_PTR;
        op        = OP_WRITE;
        if (filled_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
          target     = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
          addr[15:8] = target[15:8];
          data       = target[7:0];
        end
      end else if (pick < 75) begin
        addr[7:0] = PORT_LO_SET + 8'($urandom_range(0, 6));
      end
      // Turn a read of a never-written entry into a write
      if (addr[7:0] == PORT_DATA && op == OP_READ &&
          !filled.exists(int'(gen_ptr) & STORE_MASK)) begin
        op = OP_WRITE;
      end
      issue_access(op, addr, data);
    end
    in_ch.valid <= 1'b0;

    // Drain, then keep watching for stray result words before the verdict
    waited = 0;
    while (replies_outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    if (fail_count == 0 && replies_outstanding == 0) begin
      $display("io_bank_switch_and_ram_file verification clean");
    end else begin
      $display("io_bank_switch_and_ram_file verification failed");
    end
    $finish;
  end

endmodule
